// ===== src/set_assoc_cache_fifo_lookup_assert.svh =====
// Assertion macros shared by the cache lookup RTL
`ifndef SET_ASSOC_CACHE_FIFO_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_FIFO_LOOKUP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SACF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sacf assertion failed");

// next-cycle implication, disabled during reset
`define SACF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sacf assertion failed");

`endif

// ===== src/sacf_pkg.sv =====
// Shared types and constants for the set-associative cache lookup
`default_nettype none

package sacf_pkg;

    localparam int LINES_DEFAULT  = 64;
    localparam int ADDR_W_DEFAULT = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] CFG_SET_BITS    = 2'd1;
    localparam logic [1:0] CFG_WAY_BITS    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FINISH
    } state_t;

    // clamped geometry
    typedef struct packed {
        logic [3:0] ob;
        logic [2:0] sb;
        logic [2:0] wb;
    } geom_t;

    typedef struct packed {
        logic        rd_en;
        logic [5:0]  rd_line;
        logic        wr_en;
        logic [5:0]  wr_line;
        logic [15:0] wr_tag;
        logic        fifo_rd_en;
        logic [5:0]  fifo_rd_set;
        logic        fifo_wr_en;
        logic [5:0]  fifo_wr_set;
        logic [5:0]  fifo_wr_ptr;
    } store_req_t;

    typedef struct packed {
        logic        rd_valid;
        logic [15:0] rd_tag;
        logic [5:0]  fifo_ptr;
    } store_rsp_t;

endpackage

`default_nettype wire

// ===== src/sacf_split.sv =====
// Geometry clamp and address split into offset, set and tag
`default_nettype none

module sacf_split #(
    parameter int ADDR_W = sacf_pkg::ADDR_W_DEFAULT
) (
    input  wire logic [15:0]    address,
    input  wire logic [3:0]     offset_bits,
    input  wire logic [2:0]     set_bits,
    input  wire logic [2:0]     way_bits,
    output sacf_pkg::geom_t     geom,
    output logic [7:0]          offset,
    output logic [5:0]          set_index,
    output logic [15:0]         tag
);

    localparam int KEEP = (ADDR_W < 16) ? ADDR_W : 16;
    localparam logic [15:0] AMASK = 16'(16'hFFFF >> (16 - KEEP));

    logic [15:0] addr_m;
    logic [15:0] off_full;
    logic [15:0] set_sh;
    logic [4:0]  tag_sh;
    logic [2:0]  way_lim;

    always_comb
    begin
        geom.ob = (offset_bits > 4'd8) ? 4'd8 : offset_bits;
        geom.sb = (set_bits > 3'd6) ? 3'd6 : set_bits;
        way_lim = 3'(3'd6 - geom.sb);
        geom.wb = (way_bits > way_lim) ? way_lim : way_bits;

        addr_m    = address & AMASK;
        off_full  = addr_m & ~(16'hFFFF << geom.ob);
        offset    = off_full[7:0];
        set_sh    = addr_m >> geom.ob;
        set_index = set_sh[5:0] & ~(6'h3F << geom.sb);
        tag_sh    = 5'({1'b0, geom.ob} + {2'b00, geom.sb});
        tag       = addr_m >> tag_sh;
    end

endmodule

`default_nettype wire

// ===== src/sacf_store.sv =====
// Tag memory, line valid bits and per-set FIFO pointer memory
`default_nettype none

module sacf_store #(
    parameter int LINES = sacf_pkg::LINES_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sacf_pkg::store_req_t req,
    output sacf_pkg::store_rsp_t      rsp
);

    // at most 64 lines are reachable with six set+way bits
    localparam int SD = (LINES < 64) ? LINES : 64;
    localparam int IW = (SD > 1) ? $clog2(SD) : 1;

    logic [15:0]   tag_mem [SD];
    logic [5:0]    fifo_mem [SD];
    logic [SD-1:0] valid_reg;
    logic [SD-1:0] fifo_ok_reg;

    logic [15:0] tag_rd_reg;
    logic        line_ok_reg;
    logic [5:0]  fifo_rd_reg;
    logic        fifo_rd_ok_reg;

    logic       rd_in_range;
    logic       wr_in_range;
    logic       fwr_in_range;
    logic [5:0] fifo_rd_idx;

    assign rd_in_range  = {1'b0, req.rd_line} < 7'(SD);
    assign wr_in_range  = {1'b0, req.wr_line} < 7'(SD);
    assign fwr_in_range = {1'b0, req.fifo_wr_set} < 7'(SD);
    assign fifo_rd_idx  = req.fifo_rd_set & 6'(LINES - 1);

    always_ff @(posedge clk)
    begin
        if (req.wr_en && wr_in_range)
        begin
            tag_mem[req.wr_line[IW-1:0]] <= req.wr_tag;
        end
        if (req.rd_en)
        begin
            tag_rd_reg <= tag_mem[req.rd_line[IW-1:0]];
        end
        if (req.fifo_wr_en && fwr_in_range)
        begin
            fifo_mem[req.fifo_wr_set[IW-1:0]] <= req.fifo_wr_ptr;
        end
        if (req.fifo_rd_en)
        begin
            fifo_rd_reg <= fifo_mem[fifo_rd_idx[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            fifo_ok_reg    <= '0;
            line_ok_reg    <= 1'b0;
            fifo_rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en && wr_in_range)
            begin
                valid_reg[req.wr_line[IW-1:0]] <= 1'b1;
            end
            if (req.fifo_wr_en && fwr_in_range)
            begin
                fifo_ok_reg[req.fifo_wr_set[IW-1:0]] <= 1'b1;
            end
            if (req.rd_en)
            begin
                line_ok_reg <= rd_in_range && valid_reg[req.rd_line[IW-1:0]];
            end
            if (req.fifo_rd_en)
            begin
                fifo_rd_ok_reg <= fifo_ok_reg[fifo_rd_idx[IW-1:0]];
            end
        end
    end

    assign rsp.rd_valid = line_ok_reg;
    assign rsp.rd_tag   = tag_rd_reg;
    // pointer never written reads as zero
    assign rsp.fifo_ptr = fifo_rd_ok_reg ? fifo_rd_reg : 6'd0;

endmodule

`default_nettype wire

// ===== src/set_assoc_cache_fifo_lookup.sv =====
// Set-associative cache lookup with FIFO replacement, top level
//
//  port group              dir   handshake
//  cfg_we/index/data       in    written at any edge with cfg_we high
//  start + address         in    taken when start high and busy low
//  done + hit/tag/...      out   one-cycle strobe, no back-pressure
//
//  One tag memory read per way, a read state then a compare state for each, ways
//  scanned in order until a hit or the last way of the set.
//  done is registered from the FINISH state, which follows the last compare.
//  busy drops in the cycle done is shown; a new word may be taken then.
//  Reset clears line valid bits and FIFO pointers at once; no clearing pass.
//  Results cannot be stalled by the receiver.
`default_nettype none
`include "set_assoc_cache_fifo_lookup_assert.svh"

module set_assoc_cache_fifo_lookup #(
    parameter int LINES  = sacf_pkg::LINES_DEFAULT,
    parameter int ADDR_W = sacf_pkg::ADDR_W_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data,
    input  wire logic        start,
    input  wire logic [15:0] address,
    output logic             busy,
    output logic             done,
    output logic             hit,
    output logic [15:0]      tag,
    output logic [5:0]       set_index,
    output logic [7:0]       offset,
    output logic [5:0]       way
);

    sacf_pkg::state_t state_reg, state_next;

    logic [3:0] offset_bits_reg;
    logic [2:0] set_bits_reg;
    logic [2:0] way_bits_reg;

    logic [2:0]  wb_reg, wb_next;
    logic [5:0]  set_reg, set_next;
    logic [15:0] tag_reg, tag_next;
    logic [7:0]  off_reg, off_next;
    logic [5:0]  w_reg, w_next;
    logic        hit_reg, hit_next;
    logic        free_reg, free_next;
    logic [5:0]  free_way_reg, free_way_next;
    logic [5:0]  way_reg, way_next;
    logic        done_reg, done_next;

    sacf_pkg::geom_t      geom;
    logic [7:0]           sp_offset;
    logic [5:0]           sp_set;
    logic [15:0]          sp_tag;
    sacf_pkg::store_req_t req;
    sacf_pkg::store_rsp_t rsp;

    logic [5:0] wmask;
    logic [5:0] base;
    logic [5:0] victim;
    logic       match;

    sacf_split #(
        .ADDR_W (ADDR_W)
    ) u_split (
        .address     (address),
        .offset_bits (offset_bits_reg),
        .set_bits    (set_bits_reg),
        .way_bits    (way_bits_reg),
        .geom        (geom),
        .offset      (sp_offset),
        .set_index   (sp_set),
        .tag         (sp_tag)
    );

    sacf_store #(
        .LINES (LINES)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= 4'd4;
            set_bits_reg    <= 3'd3;
            way_bits_reg    <= 3'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sacf_pkg::CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                sacf_pkg::CFG_SET_BITS:    set_bits_reg    <= cfg_data[2:0];
                sacf_pkg::CFG_WAY_BITS:    way_bits_reg    <= cfg_data[2:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sacf_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_reg       <= wb_next;
        set_reg      <= set_next;
        tag_reg      <= tag_next;
        off_reg      <= off_next;
        w_reg        <= w_next;
        free_way_reg <= free_way_next;
        way_reg      <= way_next;
    end

    // ways - 1, and first line of the set
    assign wmask  = 6'(~(6'h3F << wb_reg));
    assign base   = 6'(set_reg << wb_reg);
    assign victim = rsp.fifo_ptr & wmask;
    assign match  = rsp.rd_valid && (rsp.rd_tag == tag_reg);

    always_comb
    begin
        state_next    = state_reg;
        wb_next       = wb_reg;
        set_next      = set_reg;
        tag_next      = tag_reg;
        off_next      = off_reg;
        w_next        = w_reg;
        hit_next      = hit_reg;
        free_next     = free_reg;
        free_way_next = free_way_reg;
        way_next      = way_reg;
        done_next     = 1'b0;
        req           = '0;

        unique case (state_reg)
            sacf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    wb_next         = geom.wb;
                    set_next        = sp_set;
                    tag_next        = sp_tag;
                    off_next        = sp_offset;
                    w_next          = 6'd0;
                    hit_next        = 1'b0;
                    free_next       = 1'b0;
                    req.fifo_rd_en  = 1'b1;
                    req.fifo_rd_set = sp_set;
                    state_next      = sacf_pkg::ST_READ;
                end
            end
            sacf_pkg::ST_READ:
            begin
                req.rd_en   = 1'b1;
                req.rd_line = base | w_reg;
                state_next  = sacf_pkg::ST_CMP;
            end
            sacf_pkg::ST_CMP:
            begin
                if (match)
                begin
                    hit_next   = 1'b1;
                    way_next   = w_reg;
                    state_next = sacf_pkg::ST_FINISH;
                end
                else
                begin
                    // first invalid way is the fill candidate
                    if (!rsp.rd_valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_way_next = w_reg;
                    end
                    if (w_reg == wmask)
                    begin
                        state_next = sacf_pkg::ST_FINISH;
                    end
                    else
                    begin
                        w_next     = 6'(w_reg + 6'd1);
                        state_next = sacf_pkg::ST_READ;
                    end
                end
            end
            sacf_pkg::ST_FINISH:
            begin
                if (!hit_reg)
                begin
                    way_next    = free_reg ? free_way_reg : victim;
                    req.wr_en   = 1'b1;
                    req.wr_line = base | way_next;
                    req.wr_tag  = tag_reg;
                    if (!free_reg)
                    begin
                        req.fifo_wr_en  = 1'b1;
                        req.fifo_wr_set = set_reg;
                        req.fifo_wr_ptr = 6'(victim + 6'd1) & wmask;
                    end
                end
                done_next  = 1'b1;
                state_next = sacf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sacf_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != sacf_pkg::ST_IDLE);
    assign done      = done_reg;
    assign hit       = hit_reg;
    assign tag       = tag_reg;
    assign set_index = set_reg;
    assign offset    = off_reg;
    assign way       = way_reg;

    `SACF_ASSERT_NOW(a_done_idle, clk, rst_n, done_reg, state_reg == sacf_pkg::ST_IDLE)
    `SACF_ASSERT_NEXT(a_start_read, clk, rst_n, start && !busy, state_reg == sacf_pkg::ST_READ)
    `SACF_ASSERT_NEXT(a_read_cmp, clk, rst_n, state_reg == sacf_pkg::ST_READ, state_reg == sacf_pkg::ST_CMP)
    `SACF_ASSERT_NOW(a_way_in_set, clk, rst_n, done_reg, (way_reg & ~wmask) == 6'd0)
    `SACF_ASSERT_NEXT(a_finish_done, clk, rst_n, state_reg == sacf_pkg::ST_FINISH, done_reg)

endmodule

`default_nettype wire

// ===== verif/set_assoc_cache_fifo_lookup_tb.sv =====
// Testbench for the set-associative cache lookup: scoreboard predictor, directed and random words
`default_nettype none

typedef struct {
    logic        hit;
    logic [15:0] tag;
    logic [5:0]  set_index;
    logic [7:0]  offset;
    logic [5:0]  way;
} lookup_t;

class lookup_scoreboard;
    logic [15:0] tag_mem[64];
    bit          line_ok[64];
    logic [5:0]  fifo_ptr[64];
    logic [3:0]  offset_bits;
    logic [2:0]  set_bits;
    logic [2:0]  way_bits;
    lookup_t     expected_q[$];
    int          fail_count;

    function new();
        foreach (line_ok[i])
        begin
            line_ok[i] = 1'b0;
            fifo_ptr[i] = '0;
            tag_mem[i] = '0;
        end
        offset_bits = 4'd4;
        set_bits = 3'd3;
        way_bits = 3'd0;
        fail_count = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] val);
        case (idx)
            sacf_pkg::CFG_OFFSET_BITS: offset_bits = val;
            sacf_pkg::CFG_SET_BITS:    set_bits = val[2:0];
            sacf_pkg::CFG_WAY_BITS:    way_bits = val[2:0];
            default: ;
        endcase
    endfunction

    // saturated geometry as the block sees it
    function void geometry(output int ob, output int sbt, output int ways);
        int wb;
        ob = (offset_bits > 8) ? 8 : int'(offset_bits);
        sbt = (set_bits > 6) ? 6 : int'(set_bits);
        wb = (way_bits > 6 - sbt) ? 6 - sbt : int'(way_bits);
        ways = 1 << wb;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_address(logic [15:0] a);
        int ob;
        int sbt;
        int ways;
        int set_no;
        int base;
        int pick;
        int free_w;
        bit hit_f;
        bit free_f;
        logic [15:0] tg;
        lookup_t exp_l;
        geometry(ob, sbt, ways);
        set_no = (int'(a) >> ob) & ((1 << sbt) - 1);
        tg = a >> (ob + sbt);
        base = set_no * ways;
        hit_f = 1'b0;
        free_f = 1'b0;
        pick = 0;
        free_w = 0;
        for (int w = 0; w < ways; w++)
        begin
            if (line_ok[base + w])
            begin
                if (!hit_f && tag_mem[base + w] == tg)
                begin
                    hit_f = 1'b1;
                    pick = w;
                end
            end
            else if (!free_f)
            begin
                free_f = 1'b1;
                free_w = w;
            end
        end
        if (!hit_f)
        begin
            if (free_f)
            begin
                pick = free_w;
            end
            else
            begin
                // pointer may be stale from a wider geometry
                pick = int'(fifo_ptr[set_no]) & (ways - 1);
                fifo_ptr[set_no] = 6'((pick + 1) & (ways - 1));
            end
            tag_mem[base + pick] = tg;
            line_ok[base + pick] = 1'b1;
        end
        exp_l.hit = hit_f;
        exp_l.tag = tg;
        exp_l.set_index = 6'(set_no);
        exp_l.offset = 8'(int'(a) & ((1 << ob) - 1));
        exp_l.way = 6'(pick);
        expected_q.push_back(exp_l);
    endfunction

    function void check_lookup(logic h, logic [15:0] t, logic [5:0] s, logic [7:0] o,
                               logic [5:0] w);
        lookup_t exp_l;
        if (expected_q.size() == 0)
        begin
            $error("result word with no lookup pending");
            fail_count++;
            return;
        end
        exp_l = expected_q.pop_front();
        if (h !== exp_l.hit)
        begin
            $error("hit: expected %0d, actual %0d", exp_l.hit, h);
            fail_count++;
        end
        if (t !== exp_l.tag)
        begin
            $error("tag: expected %0h, actual %0h", exp_l.tag, t);
            fail_count++;
        end
        if (s !== exp_l.set_index)
        begin
            $error("set_index: expected %0d, actual %0d", exp_l.set_index, s);
            fail_count++;
        end
        if (o !== exp_l.offset)
        begin
            $error("offset: expected %0d, actual %0d", exp_l.offset, o);
            fail_count++;
        end
        if (w !== exp_l.way)
        begin
            $error("way: expected %0d, actual %0d", exp_l.way, w);
            fail_count++;
        end
    endfunction
endclass

module set_assoc_cache_fifo_lookup_tb;

    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         PHASES      = 12;
    localparam int         PHASE_WORDS = 90;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;
    logic        start = 1'b0;
    logic [15:0] address = '0;
    logic        busy;
    logic        done;
    logic        hit;
    logic [15:0] tag;
    logic [5:0]  set_index;
    logic [7:0]  offset;
    logic [5:0]  way;

    lookup_scoreboard board = new();
    int cycle_count = 0;
    int burst_left = 0;

    set_assoc_cache_fifo_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .address   (address),
        .busy      (busy),
        .done      (done),
        .hit       (hit),
        .tag       (tag),
        .set_index (set_index),
        .offset    (offset),
        .way       (way)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_lookup(hit, tag, set_index, offset, way);
            if (start && !busy)
                board.note_address(address);
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic lookup(input logic [15:0] addr);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else if ($urandom_range(0, 14) == 0)
        begin
            burst_left = $urandom_range(20, 60);
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 17);
        end
        if (gap != 0)
        begin
            start <= 1'b0;
            address <= 16'($urandom);
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        address <= addr;
        while (busy) @(negedge clk);
        @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        board.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic set_geometry(input logic [3:0] ob, input logic [3:0] sbt,
                                input logic [3:0] wb, input bit junk_write);
        drain();
        write_reg(sacf_pkg::CFG_OFFSET_BITS, ob);
        write_reg(sacf_pkg::CFG_SET_BITS, sbt);
        write_reg(sacf_pkg::CFG_WAY_BITS, wb);
        if (junk_write)
            write_reg(CFG_UNUSED, 4'hF);
        cfg_we <= 1'b0;
        cfg_index <= 2'($urandom);
        cfg_data <= 4'($urandom);
        @(negedge clk);
    endtask

    initial
    begin
        logic [3:0] geo_ob[8];
        logic [3:0] geo_sb[8];
        logic [3:0] geo_wb[8];
        logic [15:0] tag_base;
        int ob;
        int sbt;
        int ways;
        int tg;
        int addr;

        geo_ob = '{4'd0, 4'd8, 4'd15, 4'd0, 4'd4, 4'd2, 4'd1, 4'd3};
        geo_sb = '{4'd0, 4'd6, 4'd15, 4'd0, 4'd3, 4'd2, 4'd5, 4'd6};
        geo_wb = '{4'd0, 4'd6, 4'd15, 4'd6, 4'd3, 4'd4, 4'd1, 4'd0};

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry, direct mapped: fill, hit, conflict eviction
        lookup(16'h0000);
        lookup(16'h0000);
        lookup(16'hFFFF);
        lookup(16'hFFFF);
        lookup(16'h0080);
        lookup(16'h0000);

        // fully associative, four ways; stray write to an unused index
        set_geometry(4'd0, 4'd0, 4'd2, 1'b1);
        for (int i = 1; i <= 7; i++)
            lookup(16'(i));
        lookup(16'h0003);
        // shrink to two ways: FIFO pointer gets masked, contents kept
        set_geometry(4'd0, 4'd0, 4'd1, 1'b0);
        lookup(16'h0009);
        lookup(16'h000A);
        lookup(16'h0002);

        // all registers past their limits
        set_geometry(4'hF, 4'hF, 4'hF, 1'b0);
        lookup(16'h7FFF);
        lookup(16'hFFFF);
        lookup(16'h7FFF);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 8)
                set_geometry(geo_ob[p], geo_sb[p], geo_wb[p], 1'b0);
            else
                set_geometry(4'($urandom), 4'($urandom), 4'($urandom), 1'b0);
            board.geometry(ob, sbt, ways);
            tag_base = 16'($urandom);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    addr = $urandom_range(0, 65535);
                end
                else
                begin
                    // small tag pool per phase so sets refill and hit
                    tg = int'(tag_base) + $urandom_range(0, ways + ways / 2 + 1);
                    addr = (tg << (ob + sbt))
                         | ($urandom_range(0, (1 << sbt) - 1) << ob)
                         | $urandom_range(0, (1 << ob) - 1);
                end
                lookup(16'(addr));
                if ($urandom_range(0, 79) == 0)
                    drain();
            end
        end

        drain();
        repeat (140) @(negedge clk);
        if (board.pending() != 0)
        begin
            $error("%0d lookups never answered", board.pending());
            board.fail_count++;
        end
        if (board.fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
